FILE: rtl/core/utt_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; used by every module under rtl/core.
package utt_pkg;

  localparam int MAX_UNITS  = 4;
  localparam int UNIT_IDX_W = 2;
  localparam int UNIT_CNT_W = 3;

  localparam logic [15:0] UNIT_REPLACEMENT = 16'hFFFD;
  localparam logic [15:0] UNIT_HIGH_BASE   = 16'hD800;
  localparam logic [15:0] UNIT_LOW_BASE    = 16'hDC00;
  localparam logic [20:0] CP_MAX           = 21'h10FFFF;
  localparam logic [20:0] CP_SUPP_BASE     = 21'h010000;
  localparam logic [20:0] CP_BMP_MAX       = 21'h00FFFF;
  localparam logic [20:0] CP_MIN_THREE     = 21'h000800;
  localparam logic [20:0] CP_MIN_TWO       = 21'h000080;
  localparam logic [1:0]  CONT_TAG         = 2'b10;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } utt_in_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        replaced;
    logic        run_last;
    logic        text_last;
  } utt_out_t;

  // All units caused by one request, oldest in entry 0.
  typedef struct packed {
    logic [MAX_UNITS-1:0][15:0]  units;
    logic [MAX_UNITS-1:0]        rep;
    logic [UNIT_CNT_W-1:0]       count;
    logic                        text_end;
  } utt_group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } utt_q_status_t;

endpackage

FILE: rtl/core/utf8_to_utf16_transcoder_top.sv
// Top level of the UTF-8 to UTF-16 transcoder: front, queue and back parts.
// Depends on utt_pkg, utt_front, utt_queue and utt_back.
//
//   channel | dir | payload               | handshake
//   in      | in  | utt_pkg::utt_in_t     | in_valid / in_stall
//   out     | out | utt_pkg::utt_out_t    | out_valid / out_stall
//
// Takes one byte per cycle while in_stall is low; the back part delivers one unit per cycle while out_stall is low.
// The first unit caused by a byte passes through a queue entry, the group register and the output register.
// in_stall rises while the queue holds QUEUE_DEPTH groups, which happens only
// when output stalls or runs of two or more units outpace the single-unit back.
// Reset clears the pending count, queue and output.
module utf8_to_utf16_transcoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  utt_pkg::utt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output utt_pkg::utt_out_t out_data
);

  utt_pkg::utt_q_status_t q_status;
  utt_pkg::utt_group_t    push_data;
  utt_pkg::utt_group_t    head;
  logic                   push;
  logic                   pop;

  utt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  utt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  utt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/utt_front.sv
// Front part: accepts bytes, holds an incomplete sequence, decodes a request
// into a group of up to four UTF-16 units. Depends on utt_pkg.
module utt_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  utt_pkg::utt_in_t       in_data,
  input  utt_pkg::utt_q_status_t q_status,
  output logic                   push,
  output utt_pkg::utt_group_t    push_data
);

  logic [7:0]       pend [3];
  logic [1:0]       pend_count;
  logic [3:0][7:0]  bytes;
  logic [2:0]       nbytes;
  logic [2:0]       pos;
  logic [2:0]       avail;
  logic [2:0]       len;
  logic [2:0]       k;
  logic             stop;
  logic [7:0]       b0;
  logic [21:0]      dec;
  logic [19:0]      cpm;
  logic [3:0][15:0] units;
  logic [3:0]       rep;
  logic [2:0]       left;
  logic             accept;

  function automatic logic [7:0] pick(input logic [3:0][7:0] b, input logic [2:0] i);
    pick = i[2] ? 8'h00 : b[i[1:0]];
  endfunction

  function automatic logic [2:0] seq_len(input logic [7:0] c);
    priority if (c[7] == 1'b0)       seq_len = 3'd1;
    else if (c[7:5] == 3'b110)       seq_len = 3'd2;
    else if (c[7:4] == 4'b1110)      seq_len = 3'd3;
    else if (c[7:3] == 5'b11110)     seq_len = 3'd4;
    else                             seq_len = 3'd0;
  endfunction

  // Returns {bad, code point}.
  function automatic logic [21:0] decode_seq(input logic [7:0] c0, input logic [7:0] c1,
                                             input logic [7:0] c2, input logic [7:0] c3,
                                             input logic [2:0] n);
    logic        bad;
    logic [20:0] cp;
    bad = 1'b0;
    if (n >= 3'd2 && c1[7:6] != utt_pkg::CONT_TAG) bad = 1'b1;
    if (n >= 3'd3 && c2[7:6] != utt_pkg::CONT_TAG) bad = 1'b1;
    if (n == 3'd4 && c3[7:6] != utt_pkg::CONT_TAG) bad = 1'b1;
    unique case (n)
      3'd1: cp = {13'd0, c0};
      3'd2: begin
        cp = {10'd0, c0[4:0], c1[5:0]};
        if (cp < utt_pkg::CP_MIN_TWO) bad = 1'b1;
      end
      3'd3: begin
        cp = {5'd0, c0[3:0], c1[5:0], c2[5:0]};
        if (cp < utt_pkg::CP_MIN_THREE) bad = 1'b1;
      end
      3'd4: begin
        cp = {c0[2:0], c1[5:0], c2[5:0], c3[5:0]};
        if (cp < utt_pkg::CP_SUPP_BASE || cp > utt_pkg::CP_MAX) bad = 1'b1;
      end
      default: begin
        cp  = '0;
        bad = 1'b1;
      end
    endcase
    decode_seq = {bad, cp};
  endfunction

  assign in_stall = q_status.full;
  assign accept   = in_valid & ~q_status.full;

  always_comb begin
    bytes  = '0;
    for (int j = 0; j < 3; j++) begin
      if (2'(j) < pend_count) bytes[j] = pend[j];
    end
    bytes[pend_count] = in_data.in_byte;
    nbytes = {1'b0, pend_count} + 3'd1;

    pos   = '0;
    k     = '0;
    stop  = 1'b0;
    units = '0;
    rep   = '0;
    b0    = '0;
    len   = '0;
    avail = '0;
    dec   = '0;
    cpm   = '0;
    for (int it = 0; it < utt_pkg::MAX_UNITS; it++) begin
      if (!stop && pos < nbytes) begin
        b0    = pick(bytes, pos);
        len   = seq_len(b0);
        avail = nbytes - pos;
        if (len == 3'd0) begin
          if (!k[2]) begin
            units[k[1:0]] = utt_pkg::UNIT_REPLACEMENT;
            rep[k[1:0]]   = 1'b1;
            k             = k + 3'd1;
          end
          pos = pos + 3'd1;
        end else if (len > avail) begin
          if (!in_data.end_of_text) begin
            stop = 1'b1;
          end else begin
            if (!k[2]) begin
              units[k[1:0]] = utt_pkg::UNIT_REPLACEMENT;
              rep[k[1:0]]   = 1'b1;
              k             = k + 3'd1;
            end
            pos = pos + 3'd1;
          end
        end else begin
          dec = decode_seq(b0, pick(bytes, pos + 3'd1), pick(bytes, pos + 3'd2),
                           pick(bytes, pos + 3'd3), len);
          if (dec[21]) begin
            if (!k[2]) begin
              units[k[1:0]] = utt_pkg::UNIT_REPLACEMENT;
              rep[k[1:0]]   = 1'b1;
              k             = k + 3'd1;
            end
            pos = pos + 3'd1;
          end else begin
            if (dec[20:0] <= utt_pkg::CP_BMP_MAX) begin
              if (!k[2]) begin
                units[k[1:0]] = dec[15:0];
                k             = k + 3'd1;
              end
            end else begin
              cpm = 20'(dec[20:0] - utt_pkg::CP_SUPP_BASE);
              if (!k[2]) begin
                units[k[1:0]] = utt_pkg::UNIT_HIGH_BASE + {6'd0, cpm[19:10]};
                k             = k + 3'd1;
              end
              if (!k[2]) begin
                units[k[1:0]] = utt_pkg::UNIT_LOW_BASE + {6'd0, cpm[9:0]};
                k             = k + 3'd1;
              end
            end
            pos = pos + len;
          end
        end
      end
    end
    left = nbytes - pos;
  end

  assign push               = accept & (k != 3'd0);
  assign push_data.units    = units;
  assign push_data.rep      = rep;
  assign push_data.count    = k;
  assign push_data.text_end = in_data.end_of_text;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= '0;
    end else if (accept) begin
      pend_count <= left[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < 3; j++) pend[j] <= pick(bytes, pos + 3'(j));
    end
  end

endmodule

FILE: rtl/core/utt_queue.sv
// Short queue of unit groups between the front and back parts.
// Depends on utt_pkg for the group and status types.
module utt_queue #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  utt_pkg::utt_group_t    push_data,
  input  logic                   pop,
  output utt_pkg::utt_group_t    head,
  output utt_pkg::utt_q_status_t status
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  utt_pkg::utt_group_t entries [DEPTH];
  logic [ADDR_W-1:0]   wr_ptr;
  logic [ADDR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]    count;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/core/utt_back.sv
// Back part: takes unit groups from the queue and delivers their units one at a
// time through an output register. Depends on utt_pkg.
module utt_back (
  input  logic                   clk,
  input  logic                   rst,
  input  utt_pkg::utt_group_t    head,
  input  utt_pkg::utt_q_status_t q_status,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output utt_pkg::utt_out_t      out_data
);

  utt_pkg::utt_group_t              grp;
  logic                             grp_valid;
  logic [utt_pkg::UNIT_IDX_W-1:0]   idx;
  logic                             load;
  logic                             adv;
  logic                             last;

  assign load = ~out_valid | ~out_stall;
  assign adv  = grp_valid & load;
  assign last = ({1'b0, idx} + 3'd1) == grp.count;
  assign pop  = ~q_status.empty & (~grp_valid | (adv & last));

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        grp_valid <= 1'b1;
        idx       <= '0;
      end else if (adv && last) begin
        grp_valid <= 1'b0;
      end else if (adv) begin
        idx <= idx + 1'b1;
      end
      if (load) begin
        out_valid <= adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      grp <= head;
    end
    if (adv) begin
      out_data.code_unit <= grp.units[idx];
      out_data.replaced  <= grp.rep[idx];
      out_data.run_last  <= last;
      out_data.text_last <= last & grp.text_end;
    end
  end

endmodule
